### src/pai_pkg.sv
package pai_pkg;

  localparam int VALUE_W    = 32;
  localparam int POS_W      = 7;
  localparam int INDEX_W    = 6;
  localparam int HELD_W     = 7;
  localparam int QUEUE_DEPTH = 2;

  // Request codes as they arrive on the input channel
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_READ,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

endpackage

### src/positional_array_insert_delete_core.sv
// Positional insert/delete list of up to CAPACITY signed 32-bit entries.
// Requests enter on the in_ channel (insert a value at a position, delete
// the entry at a position, or read out the whole list) and produce results
// on the out_ channel, each carrying a status, the held count after the
// request and a last flag. Insert, delete and unused request codes give one
// result; a read-out gives one result per held entry (or one empty-status
// result), and the back end takes no new request until the read-out ends.
// Throughput is set by the single output register and by the entry store,
// which shifts all cells in parallel on insert/delete and rotates the held
// entries past cell zero during a read-out. A two-deep command queue sits
// between the request decoder and the executing back end so that either
// side can stall alone.
// Full-list and empty-list checks are made before the position check.
module positional_array_insert_delete_core
  import pai_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_entry_value,
  output logic [INDEX_W-1:0]        out_entry_index,
  output logic [HELD_W-1:0]         out_held_count,
  output logic                      out_last
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_cmd, q_head;

  // Decode the request and hand the transaction to the queue
  pai_front u_front (
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .in_position (in_position),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  // Hold decoded commands until the back end is free
  pai_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Execute commands against the entry store and drive results
  pai_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_index (out_entry_index),
    .out_held_count  (out_held_count),
    .out_last        (out_last)
  );

endmodule

### src/pai_front.sv
module pai_front
  import pai_pkg::*;
(
  input  logic                      in_valid,
  input  logic [1:0]                in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic                      q_full,
  output logic                      in_stall,
  output logic                      q_push,
  output cmd_t                      q_cmd
);

  // Stall only while the queue has no free slot
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.value    = in_value;
    q_cmd.position = in_position;
    case (in_req_type)
      REQ_INSERT: q_cmd.op = OP_INSERT;
      REQ_DELETE: q_cmd.op = OP_DELETE;
      REQ_READ:   q_cmd.op = OP_READ;
      default:    q_cmd.op = OP_NOP;
    endcase
  end

endmodule

### src/pai_queue.sv
module pai_queue
  import pai_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/pai_back.sv
module pai_back
  import pai_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  cmd_t                      q_head,
  output logic                      q_pop,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_entry_value,
  output logic [INDEX_W-1:0]        out_entry_index,
  output logic [HELD_W-1:0]         out_held_count,
  output logic                      out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic signed [VALUE_W-1:0] cell_r   [CAPACITY];
  logic signed [VALUE_W-1:0] cell_nxt [CAPACITY];

  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic [HELD_W-1:0]         out_held_r;
  logic                      out_last_r;

  logic                      out_free, load;
  logic                      do_ins, do_del, do_rot;
  status_t                   res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic [IDX_W-1:0]          res_index;
  logic                      res_last;
  logic                      is_full, rd_last;
  logic [POS_W-1:0]          cnt_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign cnt_ext  = POS_W'(count_r);
  assign rd_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    load       = 1'b0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_rot     = 1'b0;
    res_status = STAT_OK;
    res_value  = '0;
    res_index  = '0;
    res_last   = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          case (q_head.op)
            OP_INSERT: begin
              if (is_full) begin
                res_status = STAT_FULL;
              end else if (q_head.position > cnt_ext) begin
                res_status = STAT_RANGE;
              end else begin
                do_ins    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else if (q_head.position >= cnt_ext) begin
                res_status = STAT_RANGE;
              end else begin
                do_del    = 1'b1;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_READ: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_value = cell_r[0];
                res_last  = (count_r == CNT_W'(1));
                do_rot    = 1'b1;
                if (count_r != CNT_W'(1)) begin
                  state_nxt = BK_READ;
                  idx_nxt   = IDX_W'(1);
                end
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          load      = 1'b1;
          res_value = cell_r[0];
          res_index = idx_r;
          res_last  = rd_last;
          do_rot    = 1'b1;
          idx_nxt   = idx_r + IDX_W'(1);
          if (rd_last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Each cell looks at its neighbors, cell zero and the new value: shift up, shift down or rotate
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] below;
    logic signed [VALUE_W-1:0] above;

    if (i > 0) begin : g_below
      assign below = cell_r[i-1];
    end else begin : g_below_edge
      assign below = cell_r[i];
    end

    if (i < CAPACITY - 1) begin : g_above
      assign above = cell_r[i+1];
    end else begin : g_above_edge
      assign above = cell_r[i];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (do_ins) begin
        if (POS_W'(i) == q_head.position) begin
          cell_nxt[i] = q_head.value;
        end else if (POS_W'(i) > q_head.position) begin
          cell_nxt[i] = below;
        end
      end else if (do_del) begin
        if (POS_W'(i) >= q_head.position) begin
          cell_nxt[i] = above;
        end
      end else if (do_rot) begin
        if (CNT_W'(i + 1) == count_r) begin
          cell_nxt[i] = cell_r[0];
        end else if (CNT_W'(i + 1) < count_r) begin
          cell_nxt[i] = above;
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_index_r  <= INDEX_W'(res_index);
      out_held_r   <= HELD_W'(count_nxt);
      out_last_r   <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_entry_index = out_index_r;
  assign out_held_count  = out_held_r;
  assign out_last        = out_last_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pai_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int SLOT_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  // Worst case is far above any real run: every request a full read-out,
  // every result behind the longest stall, plus the longest input gaps.
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 80;

  // Code 3 has no name in the package; the core treats it as a no-op.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic [POS_W-1:0]          POS_TOP   = '1;

  // One result transaction as the core should present it.
  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic [HELD_W-1:0]         held;
    logic                      last;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_req_type;
  logic signed [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]          in_position;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                out_status;
  logic signed [VALUE_W-1:0] out_entry_value;
  logic [INDEX_W-1:0]        out_entry_index;
  logic [HELD_W-1:0]         out_held_count;
  logic                      out_last;

  // Shadow copy of the list, updated as each request is accepted.
  logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
  int                        shadow_count;
  list_result_t              expected_results [$];
  list_result_t              next_result;

  // Idle pressure: 0 none, 1 light, 2 heavy.
  int gap_level;
  int stall_level;
  int stall_left;
  int stall_roll;

  int err_count;
  int cycle_count;
  int n_requests;
  int n_results;
  int n_inserts;
  int n_deletes;
  int n_readouts;
  int n_unused;
  int n_full;
  int n_empty;
  int n_range;
  int peak_count;

  positional_array_insert_delete_core #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_index (out_entry_index),
    .out_held_count  (out_held_count),
    .out_last        (out_last)
  );

  always #CLK_HALF clk = ~clk;

  // Free-running watchdog; a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result-side back-pressure. Mostly short stalls, now and then a long one;
  // level zero releases the channel entirely.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_level == 0) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < (stall_level == 1 ? 75 : 45)) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 97) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(8, 24);
      end
    end
  end

  // Compare every accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("Unexpected result: status %0d value %0d index %0d held %0d last %0b",
               out_status, out_entry_value, out_entry_index, out_held_count, out_last);
        err_count++;
      end else begin
        next_result = expected_results.pop_front();
        n_results++;
        if (out_status !== next_result.status) begin
          $error("status: expected %0d, got %0d", next_result.status, out_status);
          err_count++;
        end
        if (out_entry_value !== next_result.value) begin
          $error("entry_value: expected %0d, got %0d", next_result.value, out_entry_value);
          err_count++;
        end
        if (out_entry_index !== next_result.index) begin
          $error("entry_index: expected %0d, got %0d", next_result.index, out_entry_index);
          err_count++;
        end
        if (out_held_count !== next_result.held) begin
          $error("held_count: expected %0d, got %0d", next_result.held, out_held_count);
          err_count++;
        end
        if (out_last !== next_result.last) begin
          $error("last: expected %0b, got %0b", next_result.last, out_last);
          err_count++;
        end
      end
    end
  end

  // Apply one accepted request to the shadow list and queue the results it
  // should produce. Full and empty are checked ahead of the position.
  task automatic predict_list_op(input logic [1:0] req,
                                 input logic signed [VALUE_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           i;
    r.status = STAT_OK;
    r.value  = '0;
    r.index  = '0;
    r.last   = 1'b1;
    case (req)
      REQ_INSERT: begin
        n_inserts++;
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
          n_full++;
        end else if (int'(pos) > shadow_count) begin
          r.status = STAT_RANGE;
          n_range++;
        end else begin
          for (i = shadow_count; i > int'(pos); i--)
            shadow_list[SLOT_W'(i)] = shadow_list[SLOT_W'(i - 1)];
          shadow_list[SLOT_W'(pos)] = val;
          shadow_count++;
        end
        r.held = HELD_W'(shadow_count);
        expected_results.push_back(r);
      end
      REQ_DELETE: begin
        n_deletes++;
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else if (int'(pos) >= shadow_count) begin
          r.status = STAT_RANGE;
          n_range++;
        end else begin
          for (i = int'(pos); i + 1 < shadow_count; i++)
            shadow_list[SLOT_W'(i)] = shadow_list[SLOT_W'(i + 1)];
          shadow_count--;
        end
        r.held = HELD_W'(shadow_count);
        expected_results.push_back(r);
      end
      REQ_READ: begin
        n_readouts++;
        r.held = HELD_W'(shadow_count);
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
          expected_results.push_back(r);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            r.value = shadow_list[SLOT_W'(i)];
            r.index = INDEX_W'(i);
            r.last  = (i + 1 == shadow_count);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        n_unused++;
        r.held = HELD_W'(shadow_count);
        expected_results.push_back(r);
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // Idle cycles to leave before the next request, mostly short.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (gap_level == 0) return 0;
    if (roll < (gap_level == 1 ? 70 : 40)) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Bias toward the two extremes so the sign bit alone and all lower bits set both show up.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return VALUE_MIN;
    if (roll == 1) return VALUE_MAX;
    return $urandom;
  endfunction

  // Drive one request transaction at the falling edge, hold it until the
  // core takes it, then record what it should produce.
  task automatic send_request(input logic [1:0] req,
                              input logic signed [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      // Drop valid and scramble the idle payload while nothing is offered.
      in_valid    <= 1'b0;
      in_req_type <= 2'($urandom);
      in_value    <= $urandom;
      in_position <= 7'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    n_requests++;
    predict_list_op(req, val, pos);
  endtask

  // Error paths on an empty list, plus the unused request code.
  task automatic test_empty_list_errors();
    gap_level   = 1;
    stall_level = 1;
    send_request(REQ_READ, pick_value(), 7'd0);
    send_request(REQ_DELETE, pick_value(), 7'd0);
    send_request(REQ_DELETE, pick_value(), POS_TOP);
    send_request(REQ_INSERT, pick_value(), 7'd1);
    send_request(REQ_INSERT, pick_value(), POS_TOP);
    send_request(REQ_UNUSED, VALUE_MAX, POS_TOP);
  endtask

  // Inserts at front, middle and end with extreme values, then deletes at
  // the end, front and middle, with out-of-range positions in between.
  task automatic test_directed_edits();
    send_request(REQ_INSERT, VALUE_MIN, 7'd0);
    send_request(REQ_INSERT, VALUE_MAX, 7'd1);
    send_request(REQ_INSERT, -32'sd1, 7'd0);
    send_request(REQ_INSERT, 32'sd0, 7'd1);
    send_request(REQ_INSERT, 32'sh5555_5555, 7'd4);
    send_request(REQ_INSERT, pick_value(), 7'd6);
    send_request(REQ_READ, pick_value(), POS_TOP);
    send_request(REQ_DELETE, pick_value(), 7'd4);
    send_request(REQ_DELETE, pick_value(), 7'd4);
    send_request(REQ_DELETE, pick_value(), POS_TOP);
    send_request(REQ_DELETE, pick_value(), 7'd0);
    send_request(REQ_UNUSED, VALUE_MIN, 7'd0);
    send_request(REQ_DELETE, pick_value(), 7'd1);
    send_request(REQ_READ, pick_value(), 7'd0);
    send_request(REQ_DELETE, pick_value(), 7'd0);
    send_request(REQ_DELETE, pick_value(), 7'd0);
    send_request(REQ_READ, pick_value(), 7'd0);
  endtask

  // Random edits with mostly legal positions, some wild ones, and the odd
  // read-out. Steer away from the extremes so the list stays mid-sized.
  task automatic test_random_mix(input int n_items, input int gaps, input int stalls);
    int          roll;
    logic [1:0]  req;
    logic [POS_W-1:0] pos;
    gap_level   = gaps;
    stall_level = stalls;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) req = REQ_UNUSED;
      else if (roll < 15) req = REQ_READ;
      else if (roll < (shadow_count > 40 ? 45 : 65)) req = REQ_INSERT;
      else req = REQ_DELETE;
      if ($urandom_range(0, 9) == 0 || req == REQ_UNUSED || req == REQ_READ)
        pos = 7'($urandom);
      else if (req == REQ_INSERT)
        pos = 7'($urandom_range(0, shadow_count));
      else
        pos = 7'($urandom_range(0, shadow_count > 0 ? shadow_count - 1 : 0));
      send_request(req, pick_value(), pos);
    end
  endtask

  // Fill to capacity at random positions, hit the full check (also with a
  // bad position), read it all out, then drain to empty and hit empty again.
  task automatic test_fill_and_drain();
    gap_level   = 1;
    stall_level = 2;
    while (shadow_count < CAPACITY)
      send_request(REQ_INSERT, pick_value(), 7'($urandom_range(0, shadow_count)));
    send_request(REQ_INSERT, pick_value(), 7'($urandom_range(0, CAPACITY)));
    send_request(REQ_INSERT, pick_value(), POS_TOP);
    send_request(REQ_DELETE, pick_value(), 7'(CAPACITY));
    send_request(REQ_READ, pick_value(), 7'd0);
    while (shadow_count > 0)
      send_request(REQ_DELETE, pick_value(), 7'($urandom_range(0, shadow_count - 1)));
    send_request(REQ_DELETE, pick_value(), 7'($urandom_range(0, CAPACITY)));
    send_request(REQ_READ, pick_value(), 7'd0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_INSERT;
    in_value     = '0;
    in_position  = '0;
    shadow_count = 0;
    gap_level    = 0;
    stall_level  = 0;
    stall_left   = 0;

    // Hold reset, release it away from the sampling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list_errors();
    test_directed_edits();
    test_random_mix(90, 0, 0);
    test_random_mix(90, 1, 1);
    test_fill_and_drain();
    test_random_mix(90, 2, 2);

    @(negedge clk);
    in_valid <= 1'b0;

    // Release back-pressure, wait out the pending results, then idle long
    // enough to catch anything extra the core might still emit.
    stall_level = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d inserts, %0d deletes, %0d read-outs, %0d unused codes)",
             n_requests, n_inserts, n_deletes, n_readouts, n_unused);
    $display("Checked %0d results: %0d full, %0d empty, %0d out of range, peak count %0d",
             n_results, n_full, n_empty, n_range, peak_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### positional_array_insert_delete_core.f
src/pai_pkg.sv
src/pai_front.sv
src/pai_queue.sv
src/pai_back.sv
src/positional_array_insert_delete_core.sv
bench/tb_top.sv
